// File: sv/swma_pkg.sv
`default_nettype none

package swma_pkg;

  localparam int unsigned CntW  = 11;
  localparam int unsigned AvgW  = 34;
  localparam int unsigned FracW = 16;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StUpdate = 5'b00010,
    StLoad   = 5'b00100,
    StDivide = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic update;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: sv/swma_ctrl.sv
`default_nettype none

module swma_ctrl #(
  parameter int unsigned DIV_W = 45
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  swma_pkg::status_t status_i,
  output swma_pkg::cmd_t    cmd_o
);
  import swma_pkg::*;

  localparam int unsigned StepW = $clog2(DIV_W);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.cfg_write = cfg_valid_i && cfg_ready_o;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StLoad;
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        step_d     = StepW'(DIV_W - 1);
        state_d    = StDivide;
      end
      StDivide: begin
        cmd_o.step = 1'b1;
        if (step_q == '0) begin
          state_d = StFinish;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      StFinish: begin
        // hold the quotient until the output register is free
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_accept_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == StUpdate))
    else $error("accepted word did not move to update");

  a_last_step_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide && step_q == '0) |=> (state_q == StFinish))
    else $error("divider did not finish after last step");

endmodule

`default_nettype wire

// File: sv/swma_dpath.sv
`default_nettype none

module swma_dpath #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 18,
  parameter int unsigned DIV_W       = 45
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swma_pkg::cmd_t                   cmd_i,
  output swma_pkg::status_t                status_o,
  input  logic        [swma_pkg::CntW-1:0] window_size_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [swma_pkg::AvgW-1:0] average_q16_o,
  output logic        [swma_pkg::CntW-1:0] samples_used_o
);
  import swma_pkg::*;

  localparam int unsigned AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SumW   = SAMPLE_BITS + CntW;
  localparam int unsigned WinCap = (WINDOW_MAX > (2 ** CntW - 1)) ? (2 ** CntW - 1) : WINDOW_MAX;
  localparam logic [CntW-1:0] WinCapW = CntW'(WinCap);

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic        [CntW-1:0] ws_q;
  logic        [CntW-1:0] win;
  logic        [CntW-1:0] slot, slot_next;
  logic        [CntW:0]   slot_inc;
  logic        [CntW-1:0] wslot_q, wslot_d;
  logic        [CntW-1:0] count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] old_ext, new_ext;
  logic                   full;
  logic        [AW-1:0]   addr;

  logic [SumW-1:0]  mag;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW:0]    trial;
  logic             qbit;
  logic             neg_q;
  logic [DIV_W-1:0] q_full;

  logic                   out_valid_q;
  logic signed [AvgW-1:0] avg_q;
  logic        [CntW-1:0] used_q;

  // effective window: zero acts as one, clipped to the ring depth
  assign win = (ws_q == '0) ? CntW'(1) : ((ws_q > WinCapW) ? WinCapW : ws_q);

  assign slot      = (wslot_q >= win) ? '0 : wslot_q;
  assign slot_inc  = {1'b0, slot} + 1'b1;
  assign slot_next = (slot_inc >= {1'b0, win}) ? '0 : slot_inc[CntW-1:0];
  assign addr      = AW'(slot);

  assign full    = (count_q >= win);
  assign old_ext = full ? SumW'(rd_q) : '0;
  assign new_ext = SumW'(sample_q);
  assign sum_d   = sum_q - old_ext + new_ext;
  assign count_d = full ? win : (count_q + 1'b1);
  assign wslot_d = slot_next;

  // ring store, read at accept, written at update
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring[addr] <= sample_q;
    end
    if (cmd_i.accept) begin
      rd_q <= ring[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= CntW'(1);
      wslot_q <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.cfg_write) begin
      ws_q    <= window_size_i;
      wslot_q <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.update) begin
      wslot_q <= wslot_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // restoring radix-2 divider on the magnitude, sign applied at the end
  assign mag   = sum_q[SumW-1] ? SumW'(~sum_q + 1'b1) : SumW'(sum_q);
  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, count_q});

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      dq_d  = {mag, {FracW{1'b0}}};
      rem_d = '0;
    end else if (cmd_i.step) begin
      dq_d  = {dq_q[DIV_W-2:0], qbit};
      rem_d = qbit ? CntW'(trial - {1'b0, count_q}) : trial[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      neg_q <= sum_q[SumW-1];
    end
  end

  assign q_full = neg_q ? (~dq_q + 1'b1) : dq_q;

  // output register
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      avg_q  <= signed'(q_full[AvgW-1:0]);
      used_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_q16_o  = avg_q;
  assign samples_used_o = used_q;

  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= win)
    else $error("fill count beyond window");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (count_q != '0 && rem_q < count_q))
    else $error("divider remainder out of range");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished word not presented");

endmodule

`default_nettype wire

// File: sv/sliding_window_moving_average_top.sv
`default_nettype none

// moving average over the last window_size samples (boxcar filter). each
// accepted sample replaces the oldest one once the window is full, and one
// result word follows per sample: the mean in signed q16 (truncated toward
// zero) and the number of samples it covers. a window_size of zero acts as
// one, values above WINDOW_MAX act as WINDOW_MAX (at most 2047); a write
// clears the window. a result is loaded into the output register after its
// sample is accepted, through update, load, one quotient bit per cycle of
// the radix-2 divider (SAMPLE_BITS + 27 bits) and finish. the input stalls
// from accept until finish, so a new sample is taken only once the last one
// has finished, and finish waits for as long as a stalled word holds the
// output register. one sample is in work at a time; the next one is taken
// while the last result waits in the output register.
module sliding_window_moving_average_top #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [swma_pkg::AvgW-1:0] average_q16_o,
  output logic        [swma_pkg::CntW-1:0] samples_used_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic        [swma_pkg::CntW-1:0] window_size_i
);
  import swma_pkg::*;

  localparam int unsigned DivW = SAMPLE_BITS + CntW + FracW;

  cmd_t    cmd;
  status_t status;

  swma_ctrl #(
    .DIV_W(DivW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swma_dpath #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS),
    .DIV_W      (DivW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .window_size_i (window_size_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .average_q16_o (average_q16_o),
    .samples_used_o(samples_used_o)
  );

endmodule

`default_nettype wire
